// File: hw/rtl/gwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwr_pkg
// Shared types and constants of the grid wave router: grid size, distance
// codes, item layouts and the control/status bundles between the top level
// and the routing engine.
// ----------------------------------------------------------------------------
package gwr_pkg;

   // grid geometry (coordinates are 5-bit fields, so each side is at most 32)
   localparam int GRID_W  = 32;
   localparam int GRID_H  = 32;
   localparam int COORD_W = 5;
   localparam int CELLS   = GRID_W * GRID_H;
   localparam int CELL_W  = $clog2(CELLS);

   // distance codes: real distances stay below the two marks
   localparam int                DIST_W     = 11;
   localparam logic [DIST_W-1:0] DIST_WALL  = {DIST_W{1'b1}};
   localparam logic [DIST_W-1:0] DIST_BLANK = {{(DIST_W-1){1'b1}}, 1'b0};

   // result step count saturates here
   localparam int                 STEPS_W   = 10;
   localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

   // item operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // input item
   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic               blocked;
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] goal_x;
      logic [COORD_W-1:0] goal_y;
   } req_type;

   // result item
   typedef struct packed {
      logic               no_path;
      logic [STEPS_W-1:0] remaining_steps;
      logic [COORD_W-1:0] next_x;
      logic [COORD_W-1:0] next_y;
   } rsp_type;

   // command from the top level into the engine
   typedef struct packed {
      logic    go;
      req_type req;
   } eng_cmd_type;

   // status from the engine back to the top level
   typedef struct packed {
      logic    ready;
      logic    done;
      rsp_type rsp;
   } eng_sts_type;

endpackage : gwr_pkg
`default_nettype wire

// File: hw/rtl/gwr_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwr_engine
// Wall map, distance map and wave queue memories with the sequencer that
// clears the wall map, seeds the distance map, runs the breadth-first wave
// and traces the path back from the goal.
// ----------------------------------------------------------------------------
module gwr_engine (
   input  wire                  clock,
   input  wire                  reset,
   input  gwr_pkg::eng_cmd_type cmd,
   input  wire                  ack,
   output gwr_pkg::eng_sts_type sts
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_INIT, S_POP, S_LOAD, S_NB, S_TSTEP, S_TCHK, S_DONE
   } state_type;

   // wave queue entry: distance and coordinates of a reached cell
   typedef struct packed {
      logic [gwr_pkg::DIST_W-1:0]  hops;
      logic [gwr_pkg::COORD_W-1:0] y;
      logic [gwr_pkg::COORD_W-1:0] x;
   } qent_type;

   typedef struct packed {
      logic                        ok;
      logic [gwr_pkg::COORD_W-1:0] x;
      logic [gwr_pkg::COORD_W-1:0] y;
   } nb_type;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   localparam int CW = gwr_pkg::CELL_W;
   localparam int XW = gwr_pkg::COORD_W;
   localparam int DW = gwr_pkg::DIST_W;

   // linear cell address
   function automatic logic [CW-1:0] cell_index(input logic [XW-1:0] x,
                                                input logic [XW-1:0] y);
      cell_index = CW'(CW'(y) * CW'(gwr_pkg::GRID_W)) + CW'(x);
   endfunction

   function automatic logic in_grid(input logic [XW-1:0] x, input logic [XW-1:0] y);
      in_grid = ({1'b0, x} < (XW+1)'(gwr_pkg::GRID_W)) &&
                ({1'b0, y} < (XW+1)'(gwr_pkg::GRID_H));
   endfunction

   // neighbor in one direction, with its in-grid flag
   function automatic nb_type nb_calc(input logic [XW-1:0] x, input logic [XW-1:0] y,
                                      input logic [1:0] k);
      nb_type r;
      r.x  = x;
      r.y  = y;
      r.ok = 1'b0;
      case (k)
         DIR_RIGHT: begin
            r.x  = x + 1'b1;
            r.ok = ({1'b0, x} + 1'b1) < (XW+1)'(gwr_pkg::GRID_W);
         end
         DIR_DOWN: begin
            r.y  = y + 1'b1;
            r.ok = ({1'b0, y} + 1'b1) < (XW+1)'(gwr_pkg::GRID_H);
         end
         DIR_LEFT: begin
            r.x  = x - 1'b1;
            r.ok = (x != '0);
         end
         default: begin
            r.y  = y - 1'b1;
            r.ok = (y != '0);
         end
      endcase
      return r;
   endfunction

   // memories
   logic                wall_mem [gwr_pkg::CELLS];
   logic [DW-1:0]       dist_mem [gwr_pkg::CELLS];
   qent_type            queue_mem [gwr_pkg::CELLS];

   logic                wall_we, wall_wdata, wall_rd_ff;
   logic [CW-1:0]       wall_waddr, wall_raddr;
   logic                dist_we;
   logic [CW-1:0]       dist_waddr, dist_raddr;
   logic [DW-1:0]       dist_wdata, dist_rd_ff;
   logic                queue_we;
   logic [CW-1:0]       queue_waddr, queue_raddr;
   qent_type            queue_wdata, queue_rd_ff;

   // control and datapath registers
   state_type           state_ff, state_in;
   logic [CW:0]         idx_ff, idx_in;
   logic [CW:0]         head_ff, head_in, tail_ff, tail_in;
   logic                init_vld_ff, init_vld_in;
   logic [CW-1:0]       init_idx_ff, init_idx_in;
   logic                found_ff, found_in;
   logic [DW-1:0]       glen_ff, glen_in, d_ff, d_in;
   logic [XW-1:0]       sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   qent_type            cur_ff, cur_in;
   logic [1:0]          k_ff, k_in;
   logic                nb_ok_ff, nb_ok_in;
   logic [XW-1:0]       nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic [CW-1:0]       nb_addr_ff, nb_addr_in;
   gwr_pkg::rsp_type    res_ff, res_in;

   nb_type              nb;
   logic [DW-1:0]       next_dist;
   logic [DW-1:0]       steps_full;
   logic [CW-1:0]       start_addr, goal_addr;

   assign start_addr = cell_index(sx_ff, sy_ff);
   assign goal_addr  = cell_index(gx_ff, gy_ff);
   assign next_dist  = cur_ff.hops + 1'b1;
   assign steps_full = glen_ff - 1'b1;

   // sequencer next state
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      init_vld_in = 1'b0;
      init_idx_in = idx_ff[CW-1:0];
      found_in    = found_ff;
      glen_in     = glen_ff;
      d_in        = d_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      gx_in       = gx_ff;
      gy_in       = gy_ff;
      cur_in      = cur_ff;
      k_in        = k_ff;
      nb_ok_in    = 1'b0;
      nb_x_in     = nb_x_ff;
      nb_y_in     = nb_y_ff;
      nb_addr_in  = nb_addr_ff;
      res_in      = res_ff;
      nb          = nb_calc(cur_ff.x, cur_ff.y, k_ff);

      wall_we     = 1'b0;
      wall_waddr  = idx_ff[CW-1:0];
      wall_wdata  = 1'b0;
      wall_raddr  = idx_ff[CW-1:0];
      dist_we     = 1'b0;
      dist_waddr  = nb_addr_ff;
      dist_wdata  = next_dist;
      dist_raddr  = nb_addr_ff;
      queue_we    = 1'b0;
      queue_waddr = tail_ff[CW-1:0];
      queue_wdata = '{hops: next_dist, y: nb_y_ff, x: nb_x_ff};
      queue_raddr = head_ff[CW-1:0];

      // seeding writes follow the wall reads in the next cycle
      if (init_vld_ff) begin
         dist_we    = 1'b1;
         dist_waddr = init_idx_ff;
         if (init_idx_ff == start_addr) begin
            dist_wdata = '0;
         end else if (init_idx_ff == goal_addr || !wall_rd_ff) begin
            dist_wdata = gwr_pkg::DIST_BLANK;
         end else begin
            dist_wdata = gwr_pkg::DIST_WALL;
         end
      end

      unique case (state_ff)
         // wall map cleared cell by cell after reset
         S_CLEAR: begin
            wall_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == (CW+1)'(gwr_pkg::CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.go && cmd.req.op == gwr_pkg::OP_WRITE) begin
               wall_waddr = cell_index(cmd.req.cell_x, cmd.req.cell_y);
               wall_wdata = cmd.req.blocked;
               wall_we    = in_grid(cmd.req.cell_x, cmd.req.cell_y);
            end else if (cmd.go) begin
               sx_in = cmd.req.start_x;
               sy_in = cmd.req.start_y;
               gx_in = cmd.req.goal_x;
               gy_in = cmd.req.goal_y;
               if (!in_grid(cmd.req.start_x, cmd.req.start_y) ||
                   !in_grid(cmd.req.goal_x, cmd.req.goal_y) ||
                   (cmd.req.start_x == cmd.req.goal_x &&
                    cmd.req.start_y == cmd.req.goal_y)) begin
                  res_in   = '{no_path: 1'b1, default: '0};
                  state_in = S_DONE;
               end else begin
                  queue_we    = 1'b1;
                  queue_waddr = '0;
                  queue_wdata = '{hops: '0, y: cmd.req.start_y, x: cmd.req.start_x};
                  head_in     = '0;
                  tail_in     = (CW+1)'(1);
                  found_in    = 1'b0;
                  idx_in      = '0;
                  state_in    = S_INIT;
               end
            end
         end
         // sweep the wall map into the distance map
         S_INIT: begin
            init_vld_in = (idx_ff < (CW+1)'(gwr_pkg::CELLS));
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == (CW+1)'(gwr_pkg::CELLS)) begin
               state_in = S_POP;
            end
         end
         // take the next reached cell, or finish the wave
         S_POP: begin
            if (found_ff) begin
               cur_in   = '{hops: glen_ff, y: gy_ff, x: gx_ff};
               d_in     = glen_ff;
               state_in = S_TSTEP;
            end else if (head_ff == tail_ff) begin
               res_in   = '{no_path: 1'b1, default: '0};
               state_in = S_DONE;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cur_in     = queue_rd_ff;
            nb         = nb_calc(queue_rd_ff.x, queue_rd_ff.y, DIR_RIGHT);
            nb_ok_in   = nb.ok;
            nb_x_in    = nb.x;
            nb_y_in    = nb.y;
            nb_addr_in = cell_index(nb.x, nb.y);
            dist_raddr = nb_addr_in;
            k_in       = DIR_RIGHT;
            state_in   = S_NB;
         end
         // mark a blank neighbor and queue it, read the next one
         S_NB: begin
            if (nb_ok_ff && dist_rd_ff == gwr_pkg::DIST_BLANK) begin
               dist_we  = 1'b1;
               queue_we = 1'b1;
               tail_in  = tail_ff + 1'b1;
               if (nb_addr_ff == goal_addr) begin
                  found_in = 1'b1;
                  glen_in  = next_dist;
               end
            end
            if (k_ff == DIR_UP) begin
               state_in = S_POP;
            end else begin
               k_in       = k_ff + 1'b1;
               nb         = nb_calc(cur_ff.x, cur_ff.y, k_in);
               nb_ok_in   = nb.ok;
               nb_x_in    = nb.x;
               nb_y_in    = nb.y;
               nb_addr_in = cell_index(nb.x, nb.y);
               dist_raddr = nb_addr_in;
            end
         end
         // one trace step toward the start
         S_TSTEP: begin
            if (d_ff <= DW'(1)) begin
               res_in.no_path         = 1'b0;
               res_in.remaining_steps = (steps_full > DW'(gwr_pkg::STEPS_MAX)) ?
                                        gwr_pkg::STEPS_MAX :
                                        steps_full[gwr_pkg::STEPS_W-1:0];
               res_in.next_x          = cur_ff.x;
               res_in.next_y          = cur_ff.y;
               state_in               = S_DONE;
            end else begin
               d_in       = d_ff - 1'b1;
               k_in       = DIR_RIGHT;
               nb         = nb_calc(cur_ff.x, cur_ff.y, DIR_RIGHT);
               nb_ok_in   = nb.ok;
               nb_x_in    = nb.x;
               nb_y_in    = nb.y;
               nb_addr_in = cell_index(nb.x, nb.y);
               dist_raddr = nb_addr_in;
               state_in   = S_TCHK;
            end
         end
         S_TCHK: begin
            if (nb_ok_ff && dist_rd_ff == d_ff) begin
               cur_in.x = nb_x_ff;
               cur_in.y = nb_y_ff;
               state_in = S_TSTEP;
            end else if (k_ff == DIR_UP) begin
               state_in = S_TSTEP;
            end else begin
               k_in       = k_ff + 1'b1;
               nb         = nb_calc(cur_ff.x, cur_ff.y, k_in);
               nb_ok_in   = nb.ok;
               nb_x_in    = nb.x;
               nb_y_in    = nb.y;
               nb_addr_in = cell_index(nb.x, nb.y);
               dist_raddr = nb_addr_in;
            end
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // wall map memory
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_mem[wall_waddr] <= wall_wdata;
      end
      wall_rd_ff <= wall_mem[wall_raddr];
   end

   // distance map memory
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      dist_rd_ff <= dist_mem[dist_raddr];
   end

   // wave queue memory
   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      queue_rd_ff <= queue_mem[queue_raddr];
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         idx_ff      <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         init_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         nb_ok_ff    <= 1'b0;
         k_ff        <= DIR_RIGHT;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         init_vld_ff <= init_vld_in;
         found_ff    <= found_in;
         nb_ok_ff    <= nb_ok_in;
         k_ff        <= k_in;
      end
      init_idx_ff <= init_idx_in;
      glen_ff     <= glen_in;
      d_ff        <= d_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      cur_ff      <= cur_in;
      nb_x_ff     <= nb_x_in;
      nb_y_ff     <= nb_y_in;
      nb_addr_ff  <= nb_addr_in;
      res_ff      <= res_in;
   end

   assign sts.ready = (state_ff == S_IDLE);
   assign sts.done  = (state_ff == S_DONE);
   assign sts.rsp   = res_ff;

   // queue pointers never cross and never pass the grid size
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= (CW+1)'(gwr_pkg::CELLS)))
      else $error("wave queue pointers out of order");

   // a found goal carries a positive distance
   a_goal_dist: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && found_ff) |-> (glen_ff != '0 && glen_ff < gwr_pkg::DIST_BLANK))
      else $error("goal distance invalid");

   // the trace only starts from a reached goal
   a_trace_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TSTEP && $past(state_ff) == S_POP) |-> found_ff)
      else $error("trace without a reached goal");

   // a queued cell was a blank neighbor inside the grid
   a_queue_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NB && queue_we) |-> (nb_ok_ff && dist_we))
      else $error("queue write without distance write");

endmodule : gwr_engine
`default_nettype wire

// File: hw/rtl/grid_wave_route_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_wave_route_step
// Lee wave router on a 32 by 32 grid with a stored wall map. Write items set
// one wall cell; query items return the first step and remaining length of a
// shortest 4-neighbor path, or no_path.
//
//   channel  ports                         direction  carries
//   request  req_valid req_stall req_data  in         req_type item
//   response rsp_valid rsp_stall rsp_data  out        rsp_type item
//
// A write item is done as it is accepted. A query first seeds the distance
// map from the wall map, then expands the wave one reached cell at a time
// and traces the path back one step at a time; one shared distance memory
// port sets this pace. After reset the wall map is cleared with req_stall high.
// A finished result waits in the output register while write items go on.
// ----------------------------------------------------------------------------
module grid_wave_route_step (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  gwr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output gwr_pkg::rsp_type rsp_data
);

   gwr_pkg::eng_cmd_type eng_cmd;
   gwr_pkg::eng_sts_type eng_sts;
   logic                 eng_ack;
   logic                 rsp_valid_ff, rsp_valid_in;
   gwr_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   // accept items only while the engine is idle
   assign req_stall   = !eng_sts.ready;
   assign eng_cmd.go  = req_valid && !req_stall;
   assign eng_cmd.req = req_data;

   // load the output register once it is free
   assign eng_ack = eng_sts.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (eng_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_sts.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gwr_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (eng_cmd),
      .ack   (eng_ack),
      .sts   (eng_sts)
   );

endmodule : grid_wave_route_step
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the grid wave router. Wall writes and route queries go in on
// the request channel; a breadth-first predictor with its own wall map works
// out each query's answer, and every response item is compared against the
// oldest pending answer.
// ----------------------------------------------------------------------------
module tb_top;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   gwr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   gwr_pkg::rsp_type rsp_data;

   int               errors = 0;
   int               sent_writes = 0;
   int               sent_queries = 0;
   int               checked = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   gwr_pkg::rsp_type route_answers[$];
   logic             walls[gwr_pkg::CELLS];

   grid_wave_route_step u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

   // breadth-first route from start to goal over the current walls
   function automatic gwr_pkg::rsp_type route_of(gwr_pkg::req_type q);
      int               lvl[gwr_pkg::CELLS];
      int               fifo[gwr_pkg::CELLS];
      int               head, tail, c, x, y, nx, ny, n, k, d, goal, cx, cy;
      int               dx[4];
      int               dy[4];
      gwr_pkg::rsp_type r;
      dx = '{1, 0, -1, 0};
      dy = '{0, 1, 0, -1};
      r = '0;
      r.no_path = 1'b1;
      if (q.start_x == q.goal_x && q.start_y == q.goal_y) return r;
      for (int i = 0; i < gwr_pkg::CELLS; i++) lvl[i] = walls[i] ? -1 : -2;
      goal = q.goal_y * gwr_pkg::GRID_W + q.goal_x;
      c = q.start_y * gwr_pkg::GRID_W + q.start_x;
      lvl[goal] = -2;
      lvl[c] = 0;
      head = 0;
      tail = 1;
      fifo[0] = c;
      while (head < tail && lvl[goal] == -2) begin
         c = fifo[head];
         head++;
         x = c % gwr_pkg::GRID_W;
         y = c / gwr_pkg::GRID_W;
         for (k = 0; k < 4; k++) begin
            nx = x + dx[k];
            ny = y + dy[k];
            if (nx < 0 || nx >= gwr_pkg::GRID_W || ny < 0 || ny >= gwr_pkg::GRID_H)
               continue;
            n = ny * gwr_pkg::GRID_W + nx;
            if (lvl[n] == -2) begin
               lvl[n] = lvl[c] + 1;
               fifo[tail] = n;
               tail++;
            end
         end
      end
      if (lvl[goal] < 1) return r;
      // trace back, neighbors tried right, down, left, up
      cx = q.goal_x;
      cy = q.goal_y;
      d = lvl[goal];
      while (d > 1) begin
         d--;
         for (k = 0; k < 4; k++) begin
            nx = cx + dx[k];
            ny = cy + dy[k];
            if (nx < 0 || nx >= gwr_pkg::GRID_W || ny < 0 || ny >= gwr_pkg::GRID_H)
               continue;
            if (lvl[ny * gwr_pkg::GRID_W + nx] == d) begin
               cx = nx;
               cy = ny;
               break;
            end
         end
      end
      r.no_path = 1'b0;
      r.remaining_steps = (lvl[goal] - 1 > int'(gwr_pkg::STEPS_MAX)) ?
                          gwr_pkg::STEPS_MAX : 10'(lvl[goal] - 1);
      r.next_x = 5'(cx);
      r.next_y = 5'(cy);
      return r;
   endfunction

   // send one item, predicting its answer
   task automatic send_item(gwr_pkg::req_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.op == gwr_pkg::OP_WRITE) begin
         walls[it.cell_y * gwr_pkg::GRID_W + it.cell_x] = it.blocked;
         sent_writes++;
      end else begin
         route_answers = {route_answers, route_of(it)};
         sent_queries++;
      end
      @(negedge clock);
   endtask

   task automatic write_cell(int x, int y, bit b);
      gwr_pkg::req_type it;
      it = '0;
      it.op = gwr_pkg::OP_WRITE;
      it.cell_x = 5'(x);
      it.cell_y = 5'(y);
      it.blocked = b;
      send_item(it);
   endtask

   task automatic query(int sx, int sy, int gx, int gy);
      gwr_pkg::req_type it;
      it = $urandom;
      it.op = gwr_pkg::OP_QUERY;
      it.start_x = 5'(sx);
      it.start_y = 5'(sy);
      it.goal_x = 5'(gx);
      it.goal_y = 5'(gy);
      send_item(it);
   endtask

   // response checker
   always @(posedge clock) begin
      gwr_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (route_answers.size() == 0) begin
            $error("response item with no pending query");
            errors++;
         end else begin
            e = route_answers.pop_front();
            checked++;
            if (rsp_data.no_path !== e.no_path) begin
               $error("no_path expected %0d actual %0d", e.no_path, rsp_data.no_path);
               errors++;
            end
            if (rsp_data.remaining_steps !== e.remaining_steps) begin
               $error("remaining_steps expected %0d actual %0d",
                      e.remaining_steps, rsp_data.remaining_steps);
               errors++;
            end
            if (rsp_data.next_x !== e.next_x) begin
               $error("next_x expected %0d actual %0d", e.next_x, rsp_data.next_x);
               errors++;
            end
            if (rsp_data.next_y !== e.next_y) begin
               $error("next_y expected %0d actual %0d", e.next_y, rsp_data.next_y);
               errors++;
            end
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
   end

   // corners, walled endpoints, start equal to goal, blocked goal
   task automatic test_directed();
      query(0, 0, 31, 31);
      query(31, 31, 0, 0);
      query(5, 5, 5, 5);
      query(0, 0, 1, 0);
      query(0, 31, 31, 0);
      write_cell(0, 0, 1'b1);
      write_cell(31, 31, 1'b1);
      query(0, 0, 31, 31);
      // fence the goal in completely
      write_cell(9, 10, 1'b1);
      write_cell(11, 10, 1'b1);
      write_cell(10, 9, 1'b1);
      write_cell(10, 11, 1'b1);
      query(2, 3, 10, 10);
      query(10, 10, 2, 3);
      write_cell(9, 10, 1'b0);
      query(2, 3, 10, 10);
      // wall down column 15 with a gap in the bottom row, forcing a detour
      for (int y = 0; y < 31; y++) write_cell(15, y, 1'b1);
      query(0, 0, 31, 0);
      for (int y = 0; y < 31; y++) write_cell(15, y, 1'b0);
      write_cell(0, 0, 1'b0);
      write_cell(31, 31, 1'b0);
      query(16, 16, 16, 17);
   endtask

   // random walls with random queries
   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 65)
            write_cell($urandom_range(31), $urandom_range(31), $urandom_range(99) < 40);
         else if ($urandom_range(9) == 0)
            query($urandom_range(31), $urandom_range(31),
                  $urandom_range(31), $urandom_range(31));
         else
            query($urandom_range(31), $urandom_range(31),
                  $urandom_range(31), $urandom_range(31));
      end
   endtask

   // dense maze with a query after every three wall writes, so unreachable goals are common
   task automatic test_dense(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 4 == 3)
            query($urandom_range(31), $urandom_range(31),
                  $urandom_range(31), $urandom_range(31));
         else
            write_cell($urandom_range(31), $urandom_range(31), 1'b1);
      end
   endtask

   initial begin
      for (int i = 0; i < gwr_pkg::CELLS; i++) walls[i] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 29;
      recv_idle_pct = 58;
      test_random(25);
      send_idle_pct = 58;
      recv_idle_pct = 29;
      test_random(25);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_dense(12);
      req_valid <= 1'b0;
      while (route_answers.size() != 0) @(posedge clock);
      repeat (8000) @(posedge clock);
      $display("covered %0d wall writes and %0d route queries, %0d responses checked",
               sent_writes, sent_queries, checked);
      if (errors == 0 && route_answers.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/gwr_pkg.sv
hw/rtl/gwr_engine.sv
hw/rtl/grid_wave_route_step.sv
test/tb_top.sv
